>>> rtl/core/deq_pkg.sv
package deq_pkg;

	// Field widths of the stream payloads.
	localparam int ACTION_W = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request codes.
	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_REMOVE     = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_FIND       = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_READ_ALL   = 4'd8;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// Command broadcast to every cell of the row.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_R,
		CELL_SHIFT_L,
		CELL_ROTATE,
		CELL_WRITE_TAIL
	} cell_op_t;

endpackage

>>> rtl/core/deq_cell.sv
module deq_cell #(
	parameter int ITEM_WIDTH = 32
) (
	input  logic                  clk,
	input  deq_pkg::cell_op_t     op,
	input  logic [ITEM_WIDTH-1:0] left_value,
	input  logic [ITEM_WIDTH-1:0] right_value,
	input  logic [ITEM_WIDTH-1:0] head_value,
	input  logic [ITEM_WIDTH-1:0] wr_value,
	input  logic                  last_sel,
	input  logic                  tail_sel,
	output logic [ITEM_WIDTH-1:0] value
);
	import deq_pkg::*;

	logic [ITEM_WIDTH-1:0] value_q;
	logic [ITEM_WIDTH-1:0] value_d;

	// The last live cell takes the front entry on a rotation, closing the ring.
	always_comb begin
		value_d = value_q;
		case (op)
			CELL_SHIFT_R:    value_d = left_value;
			CELL_SHIFT_L:    value_d = right_value;
			CELL_ROTATE:     value_d = last_sel ? head_value : right_value;
			CELL_WRITE_TAIL: value_d = tail_sel ? wr_value : value_q;
			default:         value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

>>> rtl/core/deq_chain.sv
module deq_chain #(
	parameter int DEPTH      = 16,
	parameter int ITEM_WIDTH = 32,
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  deq_pkg::cell_op_t     op,
	input  logic [ITEM_WIDTH-1:0] wr_value,
	input  logic [CW-1:0]         count,
	output logic [ITEM_WIDTH-1:0] head_value,
	output logic [ITEM_WIDTH-1:0] tail_value
);
	import deq_pkg::*;

	logic [ITEM_WIDTH-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]      last_sel;
	logic [DEPTH-1:0]      tail_sel;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_v;
		logic [ITEM_WIDTH-1:0] right_v;

		assign last_sel[i] = (count == CW'(i + 1));
		assign tail_sel[i] = (count == CW'(i));

		if (i == 0) begin : g_first
			assign left_v = wr_value;
		end else begin : g_inner
			assign left_v = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_v = cell_value[i];
		end else begin : g_mid
			assign right_v = cell_value[i+1];
		end

		deq_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.left_value (left_v),
			.right_value(right_v),
			.head_value (cell_value[0]),
			.wr_value   (wr_value),
			.last_sel   (last_sel[i]),
			.tail_sel   (tail_sel[i]),
			.value      (cell_value[i])
		);
	end

	assign head_value = cell_value[0];

	// Exactly one cell at most is marked last, so an OR of the masked values selects it.
	always_comb begin
		tail_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_value = tail_value | (cell_value[i] & {ITEM_WIDTH{last_sel[i]}});
		end
	end

endmodule

>>> rtl/core/double_ended_queue_top.sv
// Channel  Direction  Signals                           Contents (lowest bit up)
// s_axis   in         tvalid tready tdata[31:0] tuser  tdata: item_value; tuser: action
// m_axis   out        tvalid tready tdata[39:0] tuser  tdata: result_value, entry_count;
//                     tlast                             tuser: status; tlast: last_of_run
//
// Pushes, pops, peeks and unused codes need no walk; one such request can
// be accepted in every cycle while the result register drains.
// Remove, find and read-all walk the cell row, one rotation per cycle while the
// result register drains, and hold the request side until every entry has passed
// the head; with an empty queue they answer without a walk.
// A stalled result register holds the walk and blocks new requests.
// Reset clears the count and control state; the cell contents are not reset.
module double_ended_queue_top #(
	parameter int DEPTH      = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [deq_pkg::VALUE_W-1:0]    s_axis_tdata,  // item_value
	input  logic [deq_pkg::ACTION_W-1:0]   s_axis_tuser,  // action
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [39:0]                    m_axis_tdata,  // result_value, entry_count
	output logic [deq_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
	output logic                           m_axis_tlast   // last_of_run
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         steps_q, steps_d;
	logic                  found_q, found_d;
	logic [ACTION_W-1:0]   action_q, action_d;
	logic [ITEM_WIDTH-1:0] key_q, key_d;

	logic                  m_valid_q;
	logic [VALUE_W-1:0]    m_value_q;
	logic [COUNT_W-1:0]    m_count_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic                  m_last_q;

	logic                  out_free;
	logic                  accept;
	logic                  out_load;
	logic [VALUE_W-1:0]    out_value;
	logic [STATUS_W-1:0]   out_status;
	logic                  out_last;

	cell_op_t              cell_op;
	logic [ITEM_WIDTH-1:0] wr_value;
	logic [ITEM_WIDTH-1:0] head_value;
	logic [ITEM_WIDTH-1:0] tail_value;
	logic                  hit;

	// The result register is free when empty or being emptied in this cycle.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_value      = ITEM_WIDTH'(s_axis_tdata);
	assign hit           = (head_value == key_q);

	deq_chain #(
		.DEPTH     (DEPTH),
		.ITEM_WIDTH(ITEM_WIDTH),
		.CW        (CW)
	) u_chain (
		.clk       (clk),
		.op        (cell_op),
		.wr_value  (wr_value),
		.count     (count_q),
		.head_value(head_value),
		.tail_value(tail_value)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		steps_d    = steps_q;
		found_d    = found_q;
		action_d   = action_q;
		key_d      = key_q;
		cell_op    = CELL_HOLD;
		out_load   = 1'b0;
		out_value  = '0;
		out_status = ST_OK;
		out_last   = 1'b1;

		if (state_q == S_IDLE) begin
			if (accept) begin
				out_load = 1'b1;
				case (s_axis_tuser)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						if (count_q == CW'(DEPTH)) begin
							out_status = ST_FULL;
						end else begin
							cell_op = (s_axis_tuser == ACT_PUSH_FRONT) ? CELL_SHIFT_R
								: CELL_WRITE_TAIL;
							count_d = count_q + 1'b1;
						end
					end
					ACT_POP_FRONT, ACT_PEEK_FRONT: begin
						if (count_q == '0) begin
							out_status = ST_EMPTY;
						end else begin
							out_value = VALUE_W'(head_value);
							if (s_axis_tuser == ACT_POP_FRONT) begin
								cell_op = CELL_SHIFT_L;
								count_d = count_q - 1'b1;
							end
						end
					end
					ACT_POP_BACK, ACT_PEEK_BACK: begin
						if (count_q == '0) begin
							out_status = ST_EMPTY;
						end else begin
							out_value = VALUE_W'(tail_value);
							if (s_axis_tuser == ACT_POP_BACK) begin
								count_d = count_q - 1'b1;
							end
						end
					end
					ACT_REMOVE, ACT_FIND, ACT_READ_ALL: begin
						if (count_q == '0) begin
							out_status = (s_axis_tuser == ACT_READ_ALL) ? ST_EMPTY
								: ST_NOT_FOUND;
						end else begin
							// The walk produces its results later.
							out_load = 1'b0;
							state_d  = S_WALK;
							steps_d  = count_q;
							found_d  = 1'b0;
							action_d = s_axis_tuser;
							key_d    = wr_value;
						end
					end
					default: begin
						out_status = ST_OK;
					end
				endcase
			end
		end else if (out_free) begin
			// One entry passes the head of the row in each walk step.
			steps_d = steps_q - 1'b1;
			cell_op = CELL_ROTATE;
			case (action_q)
				ACT_READ_ALL: begin
					out_load  = 1'b1;
					out_value = VALUE_W'(head_value);
					out_last  = (steps_q == CW'(1));
				end
				ACT_REMOVE: begin
					if (hit && !found_q) begin
						cell_op = CELL_SHIFT_L;
						count_d = count_q - 1'b1;
						found_d = 1'b1;
					end
				end
				default: begin
					if (hit) begin
						found_d = 1'b1;
					end
				end
			endcase
			if (steps_q == CW'(1)) begin
				state_d = S_IDLE;
				if (action_q != ACT_READ_ALL) begin
					out_load   = 1'b1;
					out_status = found_d ? ST_OK : ST_NOT_FOUND;
					if (action_q == ACT_FIND && found_d) begin
						out_value = VALUE_W'(key_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			steps_q   <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			steps_q <= steps_d;
			found_q <= found_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		action_q <= action_d;
		key_q    <= key_d;
		if (out_load) begin
			m_value_q  <= out_value;
			m_status_q <= out_status;
			m_count_q  <= COUNT_W'(count_d);
			m_last_q   <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, m_count_q, m_value_q};
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

endmodule
